// ===== src/gbe_pkg.sv =====
// Shared types, constants and helper functions for the beta estimator.
`default_nettype none

package gbe_pkg;

   localparam int PIX_W       = 8;
   localparam int CFG_W       = 12;
   localparam int SUM_W       = 44;
   localparam int DIST_W      = 18;
   localparam int BETA_W      = 56;
   localparam int BETA_SHIFT  = 31;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      BACK_ACCUM  = 2'd0,
      BACK_DIVIDE = 2'd1,
      BACK_FINISH = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic has_left;
      logic has_up;
      logic has_upright;
      logic last;
   } item_flags_type;

   typedef struct packed {
      pixel_type      pix;
      pixel_type      left;
      pixel_type      upleft;
      pixel_type      up;
      pixel_type      upright;
      item_flags_type flags;
   } gbe_item_type;

   function automatic logic [2*PIX_W-1:0] chan_sq(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return (2*PIX_W)'(d) * (2*PIX_W)'(d);
   endfunction

   function automatic logic [DIST_W-1:0] sq_dist(input pixel_type a, input pixel_type b);
      return DIST_W'(chan_sq(a.red, b.red)) + DIST_W'(chan_sq(a.green, b.green))
           + DIST_W'(chan_sq(a.blue, b.blue));
   endfunction

endpackage

`default_nettype wire

// ===== src/gbe_if.sv =====
// Valid/ready stream interfaces for the pixel and result channels.
`default_nettype none

interface gbe_req_if import gbe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_red;
   logic [PIX_W-1:0] pixel_green;
   logic [PIX_W-1:0] pixel_blue;

   modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                   input ready);
   modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                   output ready);
endinterface

interface gbe_rsp_if import gbe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BETA_W-1:0] beta_value;
   logic              saturated;

   modport source (output valid, output beta_value, output saturated, input ready);
   modport sink   (input valid, input beta_value, input saturated, output ready);
endinterface

`default_nettype wire

// ===== src/gbe_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module gbe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== src/gbe_front.sv =====
// Front end: pixel intake, raster counters, line store and neighbour gathering.
`default_nettype none

module gbe_front import gbe_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
   gbe_req_if.sink                                req_if,
   output logic                                   push_valid,
   output gbe_item_type                           push_item,
   input  wire logic                              push_ready
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int DW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [XW-1:0]  x_ff, x_in;
   logic [YW-1:0]  y_ff, y_in;
   logic           s1_valid_ff, s1_valid_in;
   pixel_type      s1_pix_ff, s1_pix_in;
   item_flags_type s1_flags_ff, s1_flags_in;
   pixel_type      left_ff, left_in;
   pixel_type      upleft_ff, upleft_in;

   logic           fire;
   logic           last_col;
   logic           last_row;
   pixel_type      pix;
   logic [XW-1:0]  upright_addr;
   pixel_type      up_rd;
   pixel_type      upright_rd;

   assign req_if.ready = !s1_valid_ff || push_ready;
   assign fire         = req_if.valid && req_if.ready;
   assign pix          = '{red: req_if.pixel_red, green: req_if.pixel_green,
                           blue: req_if.pixel_blue};
   assign last_col     = (DW'(x_ff) + DW'(1)) >= width;
   assign last_row     = (HW'(y_ff) + HW'(1)) >= height;
   assign upright_addr = last_col ? '0 : (x_ff + XW'(1));

   gbe_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) line_store (
      .clock     (clock),
      .wr_en     (fire),
      .wr_addr   (x_ff),
      .wr_data   (pix),
      .rd_en     (fire),
      .rd_addr_a (x_ff),
      .rd_addr_b (upright_addr),
      .rd_data_a (up_rd),
      .rd_data_b (upright_rd)
   );

   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      s1_valid_in = s1_valid_ff && !push_ready;
      s1_pix_in   = s1_pix_ff;
      s1_flags_in = s1_flags_ff;
      left_in     = left_ff;
      upleft_in   = upleft_ff;
      if (s1_valid_ff && push_ready) begin
         left_in   = s1_pix_ff;
         upleft_in = up_rd;
      end
      if (fire) begin
         s1_valid_in             = 1'b1;
         s1_pix_in               = pix;
         s1_flags_in.has_left    = (x_ff != '0);
         s1_flags_in.has_up      = (y_ff != '0);
         s1_flags_in.has_upright = (y_ff != '0) && !last_col;
         s1_flags_in.last        = last_col && last_row;
         if (last_col) begin
            x_in = '0;
            y_in = last_row ? '0 : (y_ff + YW'(1));
         end else begin
            x_in = x_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff   <= s1_pix_in;
      s1_flags_ff <= s1_flags_in;
      left_ff     <= left_in;
      upleft_ff   <= upleft_in;
   end

   assign push_valid = s1_valid_ff;
   assign push_item  = '{pix: s1_pix_ff, left: left_ff, upleft: upleft_ff, up: up_rd,
                         upright: upright_rd, flags: s1_flags_ff};

endmodule

`default_nettype wire

// ===== src/gbe_queue.sv =====
// Short FIFO between the front end and the back end.
`default_nettype none

module gbe_queue import gbe_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push_valid,
   input  gbe_item_type push_item,
   output logic        push_ready,
   output logic        pop_valid,
   output gbe_item_type pop_item,
   input  wire logic   pop_ready
);

   gbe_item_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : (wr_ptr_ff + QUEUE_PTR_W'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : (rd_ptr_ff + QUEUE_PTR_W'(1));
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/gbe_back.sv =====
// Back end: distance accumulation, serial divider and result register.
`default_nettype none

module gbe_back import gbe_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
   input  wire logic                              pop_valid,
   input  gbe_item_type                           pop_item,
   output logic                                   pop_ready,
   gbe_rsp_if.source                              rsp_if
);

   localparam int    DW        = $clog2(MAX_WIDTH + 1);
   localparam int    HW        = $clog2(MAX_HEIGHT + 1);
   localparam int    PRW       = DW + HW;
   localparam longint PAIRS_MAX = 64'(4) * 64'(MAX_WIDTH - 1) * 64'(MAX_HEIGHT - 1)
                                + 64'(MAX_WIDTH) + 64'(MAX_HEIGHT) - 64'(2);
   localparam int    PW        = $clog2(PAIRS_MAX + 1);
   localparam int    NW        = PW + BETA_SHIFT;
   localparam int    CW        = $clog2(NW);
   localparam int    TW        = DIST_W + 2;

   back_state_type     state_ff, state_in;
   logic               a_valid_ff, a_valid_in;
   logic               a_last_ff, a_last_in;
   logic [DIST_W-1:0]  a_dist_ff [4];
   logic [DIST_W-1:0]  a_dist_in [4];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   div_ff, div_in;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [NW-1:0]      quo_ff, quo_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [PRW-1:0]     prod_ff, prod_in;
   logic               out_valid_ff, out_valid_in;
   logic [BETA_W-1:0]  beta_ff, beta_in;
   logic               sat_ff, sat_in;

   logic               pop;
   logic               out_free;
   logic               out_load;
   logic               div_step;
   logic [TW-1:0]      total;
   logic [SUM_W:0]     acc;
   logic [SUM_W-1:0]   sum_sat;
   logic [PW-1:0]      pairs;
   logic [SUM_W:0]     trial;
   logic               ge;
   logic [NW+BETA_W-1:0] quo_x;
   logic               quo_over;
   logic [DW-1:0]      wm1;
   logic [HW-1:0]      hm1;

   assign wm1     = width - DW'(1);
   assign hm1     = height - HW'(1);
   assign prod_in = PRW'(wm1) * PRW'(hm1);
   assign pairs   = PW'({prod_ff, 2'b00}) + PW'(width) + PW'(height) - PW'(2);

   assign total   = TW'(a_dist_ff[0]) + TW'(a_dist_ff[1]) + TW'(a_dist_ff[2])
                  + TW'(a_dist_ff[3]);
   assign acc     = {1'b0, sum_ff} + (SUM_W+1)'(total);
   assign sum_sat = acc[SUM_W] ? '1 : acc[SUM_W-1:0];

   assign trial    = {rem_ff, quo_ff[NW-1]};
   assign ge       = trial >= {1'b0, div_ff};
   assign quo_x    = (NW+BETA_W)'(quo_ff);
   assign quo_over = |quo_x[NW+BETA_W-1:BETA_W];

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign pop      = pop_valid && pop_ready;

   always_comb begin
      pop_ready = 1'b0;
      div_step  = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         BACK_ACCUM:  pop_ready = !(a_valid_ff && a_last_ff);
         BACK_DIVIDE: div_step  = 1'b1;
         BACK_FINISH: out_load  = out_free;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_ACCUM: begin
            if (a_valid_ff && a_last_ff) begin
               state_in = (sum_sat == '0) ? BACK_FINISH : BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = BACK_FINISH;
            end
         end
         BACK_FINISH: begin
            if (out_free) begin
               state_in = BACK_ACCUM;
            end
         end
      endcase
   end

   always_comb begin
      a_valid_in   = pop;
      a_last_in    = a_last_ff;
      a_dist_in    = a_dist_ff;
      sum_in       = sum_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      beta_in      = beta_ff;
      sat_in       = sat_ff;

      if (pop) begin
         a_last_in    = pop_item.flags.last;
         a_dist_in[0] = pop_item.flags.has_left
                      ? sq_dist(pop_item.pix, pop_item.left) : '0;
         a_dist_in[1] = (pop_item.flags.has_left && pop_item.flags.has_up)
                      ? sq_dist(pop_item.pix, pop_item.upleft) : '0;
         a_dist_in[2] = pop_item.flags.has_up
                      ? sq_dist(pop_item.pix, pop_item.up) : '0;
         a_dist_in[3] = pop_item.flags.has_upright
                      ? sq_dist(pop_item.pix, pop_item.upright) : '0;
      end

      if (a_valid_ff) begin
         if (a_last_ff) begin
            sum_in = '0;
            div_in = sum_sat;
            rem_in = '0;
            cnt_in = '0;
            quo_in = (sum_sat == '0) ? '0 : {pairs, {BETA_SHIFT{1'b0}}};
         end else begin
            sum_in = sum_sat;
         end
      end

      if (div_step) begin
         rem_in = ge ? SUM_W'(trial - {1'b0, div_ff}) : SUM_W'(trial);
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
      end

      if (out_load) begin
         out_valid_in = 1'b1;
         beta_in      = quo_over ? '1 : quo_x[BETA_W-1:0];
         sat_in       = quo_over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_ACCUM;
         a_valid_ff   <= 1'b0;
         a_last_ff    <= 1'b0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_valid_ff   <= a_valid_in;
         a_last_ff    <= a_last_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_dist_ff <= a_dist_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      beta_ff   <= beta_in;
      sat_ff    <= sat_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.beta_value = beta_ff;
   assign rsp_if.saturated  = sat_ff;

endmodule

`default_nettype wire

// ===== src/grabcut_beta_estimate_top.sv =====
// Top level of the GrabCut beta estimator: CSRs, front end, queue and back end.
//
// Usage:
//   Pixels stream in raster order on req_if (valid/ready), one transaction per pixel,
//   for a frame of frame_width x frame_height pixels set through the csr_ write port
//   (index 0: width, index 1: height; 0 acts as 1, values above the maximum clamp).
//   After the last pixel of a frame one transaction leaves on rsp_if carrying beta
//   as unsigned Q25.31 and a saturation flag; a zero distance sum gives zero.
//   Throughput: one pixel per cycle while the queue has room. The front end stores the previous row in a
//   single-port-write, dual-read line store and hands neighbour sets to the back end
//   through a two-entry queue.
//   After the last pixel the result comes from the restoring divider, which retires one
//   quotient bit per cycle of a PW+31 bit quotient; PW is the bit width of the largest
//   pair count.
//   While the divider runs the queue fills and req_if.ready drops until it finishes.
//   A stalled result holds in the output register; the next frame streams in
//   meanwhile until the following result needs that register.
//   Reset: counters, sum and handshakes clear, size registers return to 640 x 480;
//   the line store is not cleared and needs no clearing pass.
`default_nettype none

module grabcut_beta_estimate_top import gbe_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  csr_index_type         csr_index,
   input  wire logic [CFG_W-1:0] csr_wr_data,
   gbe_req_if.sink               req_if,
   gbe_rsp_if.source             rsp_if
);

   localparam int DW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic [DW-1:0]    width;
   logic [HW-1:0]    height;

   logic             push_valid;
   gbe_item_type     push_item;
   logic             push_ready;
   logic             pop_valid;
   gbe_item_type     pop_item;
   logic             pop_ready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         width = DW'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         width = DW'(MAX_WIDTH);
      end else begin
         width = DW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height = HW'(1);
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         height = HW'(MAX_HEIGHT);
      end else begin
         height = HW'(frame_height_ff);
      end
   end

   gbe_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) front (
      .clock      (clock),
      .reset      (reset),
      .width      (width),
      .height     (height),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   gbe_queue queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   gbe_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) back (
      .clock     (clock),
      .reset     (reset),
      .width     (width),
      .height    (height),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the beta estimator: runs whole frames through it and checks each beta result.
`timescale 1ns / 1ps

module tb_top import gbe_pkg::*;;

   localparam int MAX_W          = 2048;
   localparam int MAX_H          = 2048;
   localparam int SETTLE_CYCLES  = 100;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_PIXELS  = 600;
   localparam int REPORT_LIMIT   = 10;

   typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_FLAT, TEX_EXTREME} texture_type;

   typedef struct packed {
      logic [BETA_W-1:0] beta;
      logic              saturated;
   } beta_result_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   csr_index_type     csr_index;
   logic [CFG_W-1:0]  csr_wr_data;

   gbe_req_if req_bus ();
   gbe_rsp_if rsp_bus ();

   grabcut_beta_estimate_top #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus)
   );

   // estimator state as seen from outside
   logic [CFG_W-1:0]  width_reg  = FRAME_WIDTH_RESET;
   logic [CFG_W-1:0]  height_reg = FRAME_HEIGHT_RESET;
   pixel_type         row_store [0:MAX_W-1];
   pixel_type         left_pix;
   pixel_type         upleft_pix;
   int                col_pos;
   int                row_pos;
   logic [SUM_W-1:0]  dist_total;

   beta_result_type   beta_expected [$];

   int                mismatch_count;
   int                results_checked;
   int                pixels_sent;
   int                frames_done;
   bit                req_gaps_on;
   bit                rsp_gaps_on;
   int                rsp_hold_req;
   int                rsp_hold_seen;
   int                rsp_stall_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_dim(input logic [CFG_W-1:0] raw, input int limit);
      if (raw == 0) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   function automatic logic [SUM_W-1:0] color_dist(input pixel_type a, input pixel_type b);
      int dr;
      int dg;
      int db;
      dr = int'(a.red) - int'(b.red);
      dg = int'(a.green) - int'(b.green);
      db = int'(a.blue) - int'(b.blue);
      return SUM_W'(dr * dr + dg * dg + db * db);
   endfunction

   function automatic void accumulate(input logic [SUM_W-1:0] d);
      logic [SUM_W:0] t;
      t = {1'b0, dist_total} + {1'b0, d};
      dist_total = t[SUM_W] ? '1 : t[SUM_W-1:0];
   endfunction

   function automatic void advance_beta_estimate(input pixel_type p);
      int              w;
      int              h;
      pixel_type       up;
      bit              last_col;
      logic [63:0]     pairs;
      logic [63:0]     quo;
      beta_result_type r;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      up = row_store[col_pos];
      last_col = (col_pos + 1 >= w);
      if (col_pos > 0) accumulate(color_dist(p, left_pix));
      if (row_pos > 0 && col_pos > 0) accumulate(color_dist(p, upleft_pix));
      if (row_pos > 0) accumulate(color_dist(p, up));
      if (row_pos > 0 && !last_col) accumulate(color_dist(p, row_store[col_pos + 1]));
      upleft_pix = up;
      row_store[col_pos] = p;
      left_pix = p;
      if (!last_col) begin
         col_pos++;
      end else begin
         col_pos = 0;
         if (row_pos + 1 < h) begin
            row_pos++;
         end else begin
            pairs = 64'(4 * (w - 1) * (h - 1) + w + h - 2);
            r = '0;
            if (dist_total != 0) begin
               quo = (pairs << BETA_SHIFT) / 64'(dist_total);
               if (quo[63:BETA_W] != 0) begin
                  r.beta = '1;
                  r.saturated = 1'b1;
               end else begin
                  r.beta = quo[BETA_W-1:0];
               end
            end
            beta_expected.insert(beta_expected.size(), r);
            frames_done++;
            row_pos = 0;
            dist_total = '0;
         end
      end
   endfunction

   function automatic logic [PIX_W-1:0] nudge(input logic [PIX_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return PIX_W'(v);
   endfunction

   function automatic pixel_type make_pixel(input texture_type tex, input pixel_type prev);
      pixel_type p;
      case (tex)
         TEX_NOISE: p = 24'($urandom());
         TEX_SMOOTH: begin
            p.red = nudge(prev.red);
            p.green = nudge(prev.green);
            p.blue = nudge(prev.blue);
         end
         TEX_FLAT: p = prev;
         default: begin
            p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
      endcase
      return p;
   endfunction

   // valid stays high across back-to-back transactions
   task automatic send_pixel(input pixel_type p);
      int gap;
      gap = req_gaps_on ? draw_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_red <= p.red;
      req_bus.pixel_green <= p.green;
      req_bus.pixel_blue <= p.blue;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      pixels_sent++;
      advance_beta_estimate(p);
   endtask

   task automatic send_frame(input texture_type tex);
      int        w;
      int        h;
      pixel_type cur;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      cur = 24'($urandom());
      for (int i = 0; i < w * h; i++) begin
         cur = make_pixel(tex, cur);
         send_pixel(cur);
      end
   endtask

   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      while (beta_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame_size(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h);
      wait_for_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wr_data <= raw_w;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wr_data <= raw_h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      width_reg = raw_w;
      height_reg = raw_h;
   endtask

   task automatic test_directed_corners();
      pixel_type black;
      pixel_type white;
      pixel_type red;
      pixel_type green;
      pixel_type blue;
      pixel_type gray;
      black = '0;
      white = '1;
      red = {8'hFF, 8'h00, 8'h00};
      green = {8'h00, 8'hFF, 8'h00};
      blue = {8'h00, 8'h00, 8'hFF};
      gray = {8'h80, 8'h80, 8'h80};
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      set_frame_size(12'd3, 12'd2);
      for (int i = 0; i < 6; i++) send_pixel((i % 2) ? white : black);
      set_frame_size(12'd4, 12'd2);
      send_pixel(red);
      send_pixel(green);
      send_pixel(blue);
      send_pixel(white);
      send_pixel(blue);
      send_pixel(green);
      send_pixel(red);
      send_pixel(black);
      // uniform frame: zero distance sum
      set_frame_size(12'd2, 12'd2);
      repeat (4) send_pixel(gray);
      // zero dimensions act as one
      set_frame_size(12'd0, 12'd0);
      send_pixel(white);
      set_frame_size(12'd1, 12'd3);
      send_pixel(black);
      send_pixel(white);
      send_pixel(black);
   endtask

   task automatic test_extreme_sizes();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      set_frame_size(12'd200, 12'd2);
      send_frame(TEX_SMOOTH);
      set_frame_size(12'd0, 12'd40);
      send_frame(TEX_NOISE);
      set_frame_size(12'd60, 12'd0);
      send_frame(TEX_NOISE);
   endtask

   task automatic test_backpressure();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      set_frame_size(12'd4, 12'd3);
      rsp_hold_req++;
      repeat (6) send_frame(TEX_NOISE);
      // hold the sender until every result is back
      wait_for_idle();
   endtask

   task automatic test_random_frames();
      int goal;
      int pick;
      int raw_w;
      int raw_h;
      int frames;
      goal = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < goal) begin
         pick = $urandom_range(0, 15);
         raw_w = (pick == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
         raw_h = (pick == 1) ? $urandom_range(7, 16) : $urandom_range(0, 6);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         set_frame_size(CFG_W'(raw_w), CFG_W'(raw_h));
         frames = $urandom_range(1, 4);
         repeat (frames) send_frame(texture_type'($urandom_range(0, 3)));
      end
   endtask

   // receiver: random stalls plus one long hold on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req != rsp_hold_seen) begin
            rsp_hold_seen = rsp_hold_req;
            rsp_stall_left = LONG_HOLD;
         end else if (rsp_stall_left == 0 && rsp_gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall_left = draw_gap();
         end
         if (reset || rsp_stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            if (rsp_stall_left > 0) rsp_stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_result
      beta_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (beta_expected.size() == 0) begin
            log_mismatch($sformatf("unexpected result: beta %h sat %b",
                                   rsp_bus.beta_value, rsp_bus.saturated));
         end else begin
            want = beta_expected.pop_front();
            if (rsp_bus.beta_value !== want.beta || rsp_bus.saturated !== want.saturated)
               log_mismatch($sformatf("result %0d: expected beta %h sat %b, got beta %h sat %b",
                                      results_checked, want.beta, want.saturated,
                                      rsp_bus.beta_value, rsp_bus.saturated));
         end
         results_checked++;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wr_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.pixel_red <= '0;
      req_bus.pixel_green <= '0;
      req_bus.pixel_blue <= '0;
      col_pos = 0;
      row_pos = 0;
      left_pix = '0;
      upleft_pix = '0;
      dist_total = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_extreme_sizes();
      test_backpressure();
      test_random_frames();
      wait_for_idle();
      if (beta_expected.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", beta_expected.size()));
      $display("Covered %0d pixels in %0d frames, from 1x1 up to rows of 200 and columns of 40,",
               pixels_sent, frames_done);
      $display("and checked %0d beta results under random and long stalls on both channels.",
               results_checked);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
